### rtl/epr_pkg.sv
package epr_pkg;

  // Width of the measurement counter and of each stored pulse width.
  localparam int unsigned COUNT_WIDTH = 16;

  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned PRESCALE_W  = 16;
  localparam int unsigned DIST_W      = 14;
  localparam int unsigned SLOT_W      = 2;
  localparam int unsigned NUM_SLOTS   = 3;

  // Three samples summed: two extra bits of headroom.
  localparam int unsigned SUM_W       = COUNT_WIDTH + 2;

  // sum * 3714 / 65536 approximates sum / 3 / 5.882.
  localparam int unsigned SCALE_W     = 12;
  localparam int unsigned SCALE_NUM   = 3714;
  localparam int unsigned SCALE_SHIFT = 16;
  localparam int unsigned PROD_W      = SUM_W + SCALE_W;
  localparam int unsigned QUO_W       = PROD_W - SCALE_SHIFT;
  localparam int unsigned EXT_W       = (QUO_W > DIST_W) ? QUO_W : DIST_W;

  // Common width for comparing the counter against timer_top.
  localparam int unsigned CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  localparam logic [DIST_W-1:0]     DIST_MAX      = '1;
  localparam logic [CFG_W-1:0]      TIMER_TOP_RST = '1;
  localparam logic [PRESCALE_W-1:0] PRESCALE_RST  = '0;
  localparam logic [SLOT_W-1:0]     LAST_SLOT     = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_TOP = 1'b0,
    CFG_PRESCALE  = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [CFG_W-1:0]      timer_top;
    logic [PRESCALE_W-1:0] prescale;
  } cfg_t;

  // Per-transaction result of the measurement stage.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             upd;
    logic             meas;
  } meas_t;

endpackage

### rtl/epr_core.sv
module epr_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          level_i,
  input  epr_pkg::cfg_t cfg_i,
  output epr_pkg::meas_t res_o
);

  logic                               prev_q, prev_d;
  logic                               active_q, active_d;
  logic [epr_pkg::PRESCALE_W-1:0]     presc_q, presc_d;
  logic [epr_pkg::COUNT_WIDTH-1:0]    cnt_q, cnt_d;
  logic [epr_pkg::SLOT_W-1:0]         slot_q, slot_d;
  logic [epr_pkg::COUNT_WIDTH-1:0]    samp_q [epr_pkg::NUM_SLOTS];
  logic [epr_pkg::COUNT_WIDTH-1:0]    samp_d [epr_pkg::NUM_SLOTS];
  epr_pkg::meas_t                     res_q, res_d;

  logic                               presc_wrap;
  logic                               ovf;
  logic [epr_pkg::COUNT_WIDTH-1:0]    cnt_adv;
  logic [epr_pkg::PRESCALE_W-1:0]     presc_adv;
  logic                               rise;
  logic                               fall;
  logic [epr_pkg::SLOT_W-1:0]         slot_eff;

  // Prescaled counter advance, judged before the echo edge.
  always_comb begin
    presc_wrap = (presc_q >= cfg_i.prescale);
    ovf        = 1'b0;
    cnt_adv    = cnt_q;
    presc_adv  = presc_q + epr_pkg::PRESCALE_W'(1);
    if (presc_wrap) begin
      presc_adv = '0;
      if ((epr_pkg::CMP_W'(cnt_q) == epr_pkg::CMP_W'(cfg_i.timer_top)) || (&cnt_q)) begin
        cnt_adv = '0;
        ovf     = 1'b1;
      end else begin
        cnt_adv = cnt_q + epr_pkg::COUNT_WIDTH'(1);
      end
    end
  end

  assign rise     = level_i & ~prev_q;
  assign fall     = ~level_i & prev_q;
  assign slot_eff = (slot_q > epr_pkg::LAST_SLOT) ? '0 : slot_q;

  always_comb begin
    cnt_d    = cnt_adv;
    presc_d  = presc_adv;
    active_d = active_q;
    slot_d   = slot_q;
    samp_d   = samp_q;
    res_d    = '0;
    if (ovf && active_q) begin
      active_d = 1'b0;
    end else if (rise && !active_q) begin
      active_d = 1'b1;
      cnt_d    = '0;
      presc_d  = '0;
    end else if (fall && active_q) begin
      active_d         = 1'b0;
      samp_d[slot_eff] = cnt_adv;
      if (slot_eff == epr_pkg::LAST_SLOT) begin
        slot_d    = '0;
        res_d.upd = 1'b1;
        res_d.sum = epr_pkg::SUM_W'(samp_q[0]) + epr_pkg::SUM_W'(samp_q[1])
                  + epr_pkg::SUM_W'(cnt_adv);
      end else begin
        slot_d = slot_eff + epr_pkg::SLOT_W'(1);
      end
    end
    res_d.meas = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b0;
      active_q <= 1'b0;
      presc_q  <= '0;
      cnt_q    <= '0;
      slot_q   <= '0;
      samp_q   <= '{default: '0};
      res_q    <= '0;
    end else if (step_i) begin
      prev_q   <= level_i;
      active_q <= active_d;
      presc_q  <= presc_d;
      cnt_q    <= cnt_d;
      slot_q   <= slot_d;
      samp_q   <= samp_d;
      res_q    <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### rtl/epr_scale.sv
module epr_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  epr_pkg::meas_t              res_i,
  output logic [epr_pkg::DIST_W-1:0]  distance_o,
  output logic                        updated_o,
  output logic                        measuring_o
);

  logic [epr_pkg::PROD_W-1:0] prod;
  logic [epr_pkg::EXT_W-1:0]  quo;
  logic [epr_pkg::DIST_W-1:0] dist_d, dist_q;
  logic                       upd_q;
  logic                       meas_q;

  assign prod   = epr_pkg::PROD_W'(res_i.sum) * epr_pkg::PROD_W'(epr_pkg::SCALE_NUM);
  assign quo    = epr_pkg::EXT_W'(prod >> epr_pkg::SCALE_SHIFT);
  assign dist_d = (quo > epr_pkg::EXT_W'(epr_pkg::DIST_MAX)) ? epr_pkg::DIST_MAX
                                                              : quo[epr_pkg::DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0;
      upd_q  <= 1'b0;
      meas_q <= 1'b0;
    end else if (load_i) begin
      upd_q  <= res_i.upd;
      meas_q <= res_i.meas;
      if (res_i.upd) begin
        dist_q <= dist_d;
      end
    end
  end

  assign distance_o  = dist_q;
  assign updated_o   = upd_q;
  assign measuring_o = meas_q;

endmodule

### rtl/echo_pulse_ranger.sv
// Echo pulse-width ranger. Each input transaction is one sample of the echo
// line; each produces exactly one output transaction carrying the latest
// averaged distance in millimeters, a one-transaction updated flag, and the
// measuring flag. A prescaled counter (advancing every prescale+1 samples and
// wrapping after timer_top) times the high phase of the echo; every third
// captured width triggers a new average, floor(sum*3714/65536). The block
// takes one sample per clock while the receiver keeps taking results: a
// three-stage pipeline (input register, measurement state update, scaling
// multiplier with output register) carries each sample to the result. The
// state update of the counter and capture logic sets the sustained rate of
// one sample per clock. Write timer_top (index 0) and prescale (index 1)
// only while the pipeline is empty.
module echo_pulse_ranger (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [epr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [epr_pkg::CFG_W-1:0]      cfg_data_i,
  // sample channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           echo_level_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [epr_pkg::DIST_W-1:0]     distance_mm_o,
  output logic                           updated_o,
  output logic                           measuring_o
);

  epr_pkg::cfg_t  cfg_q;
  epr_pkg::meas_t b_res;

  logic a_valid_q, b_valid_q, c_valid_q;
  logic level_q;
  logic c_ready, b_ready;
  logic a_adv, b_adv;
  logic in_accept;

  // Configuration registers: take the write at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_top <= epr_pkg::TIMER_TOP_RST;
      cfg_q.prescale  <= epr_pkg::PRESCALE_RST;
    end else if (cfg_we_i) begin
      case (epr_pkg::cfg_index_e'(cfg_index_i))
        epr_pkg::CFG_TIMER_TOP: cfg_q.timer_top <= cfg_data_i;
        epr_pkg::CFG_PRESCALE:  cfg_q.prescale  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage moves on when the next one is empty or
  // draining, so the sample channel stalls only when all three stages hold
  // data and the result is waiting.
  assign c_ready    = ~c_valid_q | out_ready_i;
  assign b_ready    = ~b_valid_q | c_ready;
  assign in_ready_o = ~a_valid_q | b_ready;
  assign a_adv      = a_valid_q & b_ready;
  assign b_adv      = b_valid_q & c_ready;
  assign in_accept  = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        c_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        c_valid_q <= 1'b0;
      end
    end
  end

  // Hold the sample until the measurement stage takes it.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      level_q <= echo_level_i;
    end
  end

  // Advance the measurement state once per sample.
  epr_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (a_adv),
    .level_i (level_q),
    .cfg_i   (cfg_q),
    .res_o   (b_res)
  );

  // Scale the sum and drive the output register.
  epr_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (b_adv),
    .res_i       (b_res),
    .distance_o  (distance_mm_o),
    .updated_o   (updated_o),
    .measuring_o (measuring_o)
  );

  assign out_valid_o = c_valid_q;

  // A completed average always ends the measurement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && updated_o) |-> !measuring_o)
    else $error("updated transaction reports measuring");

  // An empty output register never stalls the sample channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !c_valid_q |-> in_ready_o)
    else $error("sample channel stalled with empty output register");

  // The held distance moves only when a new average enters the output stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(b_adv && b_res.upd) |=> $stable(distance_mm_o))
    else $error("distance changed without an update");

endmodule

### dv/echo_pulse_ranger_test.sv
`timescale 1ns / 1ps

module echo_pulse_ranger_test;

  // Three pipeline stages between the accepting edge and the result.
  localparam int unsigned PIPE_LAT       = 3;
  localparam int unsigned RANDOM_SAMPLES = 140;
  localparam int unsigned LONG_RUN       = 24;

  typedef struct packed {
    logic [epr_pkg::DIST_W-1:0] distance_mm;
    logic                       updated;
    logic                       measuring;
  } reading_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [epr_pkg::CFG_IDX_W-1:0] cfg_index_i = epr_pkg::CFG_TIMER_TOP;
  logic [epr_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic                          echo_level_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [epr_pkg::DIST_W-1:0]    distance_mm_o;
  logic                          updated_o;
  logic                          measuring_o;

  echo_pulse_ranger u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .echo_level_i  (echo_level_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .distance_mm_o (distance_mm_o),
    .updated_o     (updated_o),
    .measuring_o   (measuring_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the ranger: configuration and measurement state.
  logic [epr_pkg::CFG_W-1:0]       shadow_top = epr_pkg::TIMER_TOP_RST;
  logic [epr_pkg::PRESCALE_W-1:0]  shadow_div = epr_pkg::PRESCALE_RST;
  logic                            prev_level = 1'b0;
  logic                            capturing = 1'b0;
  logic [epr_pkg::PRESCALE_W-1:0]  div_count = '0;
  logic [epr_pkg::COUNT_WIDTH-1:0] pulse_ticks = '0;
  logic [epr_pkg::SLOT_W-1:0]      slot_sel = '0;
  logic [epr_pkg::COUNT_WIDTH-1:0] widths [epr_pkg::NUM_SLOTS];
  logic [epr_pkg::DIST_W-1:0]      distance = '0;

  reading_t    expected_readings [$];
  int unsigned samples_sent = 0;
  int unsigned readings_checked = 0;
  int unsigned distance_updates = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;

  // Shared by both sides: gaps on or off, and the long receiver hold-off.
  bit          idling_on = 1'b1;
  int unsigned holdoff_req = 0;

  initial begin
    foreach (widths[i]) widths[i] = '0;
  end

  // Advance the shadow ranger by one echo sample and return its reading.
  function automatic reading_t predict_reading(input logic level);
    reading_t                  r;
    logic                      wrapped;
    int unsigned               slot;
    logic [epr_pkg::SUM_W-1:0] total;
    logic [63:0]               scaled;
    wrapped  = 1'b0;
    r.updated = 1'b0;

    // Prescaled counter first; a wrap is an overflow.
    if (div_count >= shadow_div) begin
      div_count = '0;
      if (epr_pkg::CMP_W'(pulse_ticks) == epr_pkg::CMP_W'(shadow_top) || &pulse_ticks) begin
        pulse_ticks = '0;
        wrapped     = 1'b1;
      end else begin
        pulse_ticks = pulse_ticks + 1'b1;
      end
    end else begin
      div_count = div_count + 1'b1;
    end

    if (wrapped && capturing) begin
      capturing = 1'b0;
    end else if (level && !prev_level && !capturing) begin
      capturing   = 1'b1;
      pulse_ticks = '0;
      div_count   = '0;
    end else if (!level && prev_level && capturing) begin
      slot = (slot_sel < epr_pkg::NUM_SLOTS) ? slot_sel : 0;
      widths[slot] = pulse_ticks;
      slot++;
      if (slot >= epr_pkg::NUM_SLOTS) begin
        total  = epr_pkg::SUM_W'(widths[0]) + epr_pkg::SUM_W'(widths[1])
               + epr_pkg::SUM_W'(widths[2]);
        scaled = (64'(total) * 64'(epr_pkg::SCALE_NUM)) >> epr_pkg::SCALE_SHIFT;
        distance  = (scaled > 64'(epr_pkg::DIST_MAX)) ? epr_pkg::DIST_MAX
                                                      : epr_pkg::DIST_W'(scaled);
        r.updated = 1'b1;
        distance_updates++;
        slot = 0;
      end
      slot_sel  = epr_pkg::SLOT_W'(slot);
      capturing = 1'b0;
    end

    prev_level    = level;
    r.distance_mm = distance;
    r.measuring   = capturing;
    return r;
  endfunction

  // Mostly no gap, a fair share of short ones, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned pick;
    if (!idling_on) return 0;
    pick = $urandom_range(99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one sample; hold valid and level until the transaction is taken.
  task automatic send_sample(input logic level);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    echo_level_i <= level;
    do @(posedge clk_i); while (!in_ready_o);
    expected_readings.push_back(predict_reading(level));
    samples_sent++;
  endtask

  // Drop valid, wait for every outstanding reading, then let the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input epr_pkg::cfg_index_e idx,
                           input logic [epr_pkg::CFG_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      epr_pkg::CFG_TIMER_TOP: shadow_top = value;
      epr_pkg::CFG_PRESCALE:  shadow_div = epr_pkg::PRESCALE_W'(value);
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_pulse(input int unsigned low_run, input int unsigned high_run);
    repeat (low_run) send_sample(1'b0);
    repeat (high_run) send_sample(1'b1);
  endtask

  task automatic log_mismatch(input string what, input reading_t want, input reading_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected dist=%0d upd=%0b meas=%0b, got dist=%0d upd=%0b meas=%0b",
               $realtime, what, want.distance_mm, want.updated, want.measuring,
               got.distance_mm, got.updated, got.measuring);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when a test requests one.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned holdoff_left;
    stall_left   = 0;
    holdoff_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (holdoff_req != 0) begin
        holdoff_left = holdoff_req;
        holdoff_req  = 0;
      end
      if (holdoff_left != 0) begin
        out_ready_i <= 1'b0;
        holdoff_left--;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(3) == 0) stall_left = idle_len();
      end
    end
  end

  // Compare every taken reading against the oldest prediction.
  initial begin : result_check
    reading_t want;
    reading_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.distance_mm = distance_mm_o;
        got.updated     = updated_o;
        got.measuring   = measuring_o;
        if (expected_readings.size() == 0) begin
          log_mismatch("unexpected reading", '0, got);
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          if (got.distance_mm !== want.distance_mm || got.updated !== want.updated ||
              got.measuring !== want.measuring) begin
            log_mismatch("reading mismatch", want, got);
          end
        end
      end
    end
  end

  // Three long pulses right after reset on the reset configuration: slot
  // zero first, no register written yet. Run without gaps.
  task automatic test_full_scale();
    idling_on = 1'b0;
    repeat (epr_pkg::NUM_SLOTS) begin
      repeat (LONG_RUN) send_sample(1'b1);
      send_sample(1'b0);
    end
    drain();
    idling_on = 1'b1;
  endtask

  // Short hand-built sequence on a tiny timer: normal captures, a pulse that
  // overflows and is cancelled, the falling edge that then comes while idle,
  // and the third capture that triggers an update.
  task automatic test_directed_edges();
    logic [24:0] pattern;
    pattern = 25'b0_11_0_111_0_1111111_00_1_0_1111_0_1;
    write_reg(epr_pkg::CFG_TIMER_TOP, epr_pkg::CFG_W'(4));
    write_reg(epr_pkg::CFG_PRESCALE, '0);
    for (int i = 24; i >= 0; i--) send_sample(pattern[i]);
  endtask

  // Timer top of zero overflows on every advance; top of one wraps fast.
  task automatic test_small_tops();
    write_reg(epr_pkg::CFG_TIMER_TOP, '0);
    send_pulse(2, 3);
    send_pulse(1, 1);
    send_sample(1'b0);
    write_reg(epr_pkg::CFG_TIMER_TOP, epr_pkg::CFG_W'(1));
    write_reg(epr_pkg::CFG_PRESCALE, epr_pkg::PRESCALE_W'(1));
    repeat (3) send_pulse(1, $urandom_range(1, 5));
    send_sample(1'b0);
  endtask

  // Largest prescale barely moves the counter; shrinking it afterward leaves
  // the divider above the new terminal count.
  task automatic test_prescale_extremes();
    write_reg(epr_pkg::CFG_TIMER_TOP, epr_pkg::CFG_W'(9));
    write_reg(epr_pkg::CFG_PRESCALE, '1);
    send_pulse(2, 6);
    send_sample(1'b0);
    write_reg(epr_pkg::CFG_PRESCALE, epr_pkg::PRESCALE_W'(2));
    repeat (4) send_pulse(2, $urandom_range(1, 12));
    send_sample(1'b0);
  endtask

  // Hold the receiver off while the sender keeps offering, so the block
  // fills and stalls its input; then pause the sender until all drains.
  task automatic test_backpressure();
    write_reg(epr_pkg::CFG_TIMER_TOP, epr_pkg::CFG_W'(6));
    write_reg(epr_pkg::CFG_PRESCALE, '0);
    idling_on   = 1'b0;
    holdoff_req = 300;
    repeat (16) send_pulse($urandom_range(1, 3), $urandom_range(1, 8));
    drain();
    idling_on = 1'b1;
  endtask

  // Random configurations and mostly well-formed pulse trains; some bursts
  // are plain noise. Widths reach past the wrap point on small timers.
  task automatic test_random_pulses();
    int unsigned first;
    int unsigned pick;
    int unsigned reach;
    logic [epr_pkg::CFG_W-1:0]      top;
    logic [epr_pkg::PRESCALE_W-1:0] div;
    first = samples_sent;
    while (samples_sent - first < RANDOM_SAMPLES) begin
      pick = $urandom_range(99);
      if (pick < 65)      top = epr_pkg::CFG_W'($urandom_range(2, 12));
      else if (pick < 80) top = epr_pkg::CFG_W'(1);
      else                top = epr_pkg::CFG_W'($urandom_range(13, 65535));
      pick = $urandom_range(99);
      if (pick < 60)      div = '0;
      else if (pick < 90) div = epr_pkg::PRESCALE_W'($urandom_range(1, 3));
      else                div = epr_pkg::PRESCALE_W'($urandom_range(4, 65535));
      write_reg(epr_pkg::CFG_TIMER_TOP, top);
      write_reg(epr_pkg::CFG_PRESCALE, div);
      idling_on = ($urandom_range(3) != 0);
      reach = (top < 20 && div < 4) ? (top + 2) * (div + 1) : 12;
      repeat (5) begin
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 6)) send_sample(1'($urandom_range(1)));
        end else begin
          send_pulse($urandom_range(1, 4), $urandom_range(1, reach));
        end
      end
    end
    idling_on = 1'b1;
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_scale();
    test_directed_edges();
    test_small_tops();
    test_prescale_extremes();
    test_backpressure();
    test_random_pulses();
    drain();

    $display("Covered %0d echo samples, %0d readings checked, %0d distance updates,",
             samples_sent, readings_checked, distance_updates);
    $display("  %0d register writes, long pulses on reset settings and a receiver hold-off.",
             reg_writes);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("** echo_pulse_ranger: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** echo_pulse_ranger: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("Timeout with %0d readings outstanding", expected_readings.size());
    $display("** echo_pulse_ranger: FAILED **");
    $finish;
  end

endmodule
